### hw/rtl/ct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_pkg: shared types and constants of the contour tracer
// Grid geometry, sample and fraction widths, trace directions and phases.
// ----------------------------------------------------------------------------
package ct_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 6;
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int NCELLS      = MAX_COLS * MAX_ROWS;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int PT_W        = 14;
  localparam int CODE_W      = 4;
  localparam int GRID_W      = 7;

  typedef enum logic [1:0] {
    D_LEFT  = 2'd0,
    D_RIGHT = 2'd1,
    D_DOWN  = 2'd2,
    D_UP    = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    PH_CLASSIFY = 2'd0,
    PH_SCAN     = 2'd1,
    PH_FWD      = 2'd2,
    PH_BWD      = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_LEVEL = 2'd0,
    REG_COLS  = 2'd1,
    REG_ROWS  = 2'd2
  } reg_e;

  localparam logic OP_LOAD = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLS_RD,
    ST_CLS_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_STEP_RD,
    ST_STEP_UPD,
    ST_PAIR,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PREP,
    F_DIV
  } fstate_e;

endpackage
`default_nettype wire

### hw/rtl/ct_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_ram: generic single-port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/ct_frac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_frac: edge crossing fraction
// Computes (level - a) / (b - a) with FRAC_BITS fraction bits, truncated and
// saturated to 0..1, by restoring division at one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ct_frac (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              go_i,
  input  wire logic signed [ct_pkg::SAMPLE_BITS-1:0] a_i,
  input  wire logic signed [ct_pkg::SAMPLE_BITS-1:0] b_i,
  input  wire logic signed [ct_pkg::SAMPLE_BITS-1:0] level_i,
  output logic                                   done_o,
  output logic [ct_pkg::FRAC_W-1:0]              frac_o
);
  import ct_pkg::*;

  localparam int DW = SAMPLE_BITS + 2;
  localparam int CW = $clog2(FRAC_W + 1);
  localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << FRAC_BITS;

  fstate_e              st_q, st_d;
  logic signed [DW-1:0] num_q, num_d, den_q, den_d;
  logic [DW-1:0]        rem_q, rem_d;
  logic [FRAC_W-1:0]    quo_q, quo_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 done_d;
  logic [FRAC_W-1:0]    frac_d;
  logic signed [DW-1:0] n_s, d_s;
  logic [DW-1:0]        sub;
  logic                 ge;

  always_comb begin
    st_d   = st_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    frac_d = frac_o;
    n_s    = (den_q < 0) ? -num_q : num_q;
    d_s    = (den_q < 0) ? -den_q : den_q;
    ge     = (rem_q >= DW'(den_q));
    sub    = ge ? (rem_q - DW'(den_q)) : rem_q;
    case (st_q)
      F_IDLE: begin
        if (go_i) begin
          num_d = DW'(level_i) - DW'(a_i);
          den_d = DW'(b_i) - DW'(a_i);
          st_d  = F_PREP;
        end
      end
      F_PREP: begin
        if (den_q == 0 || n_s <= 0) begin
          frac_d = '0;
          done_d = 1'b1;
          st_d   = F_IDLE;
        end else if (n_s >= (d_s <<< 1)) begin
          frac_d = ONE;
          done_d = 1'b1;
          st_d   = F_IDLE;
        end else begin
          den_d = d_s;
          rem_d = DW'(n_s);
          quo_d = '0;
          cnt_d = CW'(FRAC_W);
          st_d  = F_DIV;
        end
      end
      F_DIV: begin
        quo_d = {quo_q[FRAC_W-2:0], ge};
        rem_d = sub << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          frac_d = ({quo_q[FRAC_W-2:0], ge} > ONE) ? ONE : {quo_q[FRAC_W-2:0], ge};
          done_d = 1'b1;
          st_d   = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_o <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    frac_o <= frac_d;
  end

endmodule
`default_nettype wire

### hw/rtl/contour_tracer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contour_tracer: marching-squares contour tracer over a stored sample grid
// Loads a 64 x 64 sample store; each advance emits a contour point or scan end.
// ----------------------------------------------------------------------------
// Usage. A word is accepted at a clock edge where start is high and busy is
// low. A load word (opcode 0) writes one sample in that same cycle and never
// raises busy. An advance word (opcode 1) raises busy from the next cycle, and
// busy falls at the edge where its single result word appears on the point
// ports, shown there for one cycle with result_valid_o.
// Configuration writes (level, grid columns, grid rows) take effect at once
// and force a new classification on the next advance if made while idle.
// Sequence. A trace step holds busy through one code read, one code write,
// two sample reads and a hand-over to the fraction divider, then through
// the divider's setup, nine quotient bits and done cycle. A flat edge, a
// ratio of zero or less, or a ratio of two or more skips the quotient bits.
// Starting a path has the scan walk, a read and a check for each cell
// visited, instead of the code read and write. The first advance after a
// load or a level, column or row write also classifies every cell, each with
// four sample reads on the single sample memory port, a capture and a code write.
// Reset clears the control state and sets level 0 and a 64 x 64 grid; the
// memories are not cleared. Results cannot be held off by the receiver, so
// the block never stalls on the output side.
// ----------------------------------------------------------------------------
module contour_tracer (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 opcode_i,
  input  wire logic [ct_pkg::COL_W-1:0]             col_i,
  input  wire logic [ct_pkg::ROW_W-1:0]             row_i,
  input  wire logic signed [ct_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [1:0]                           cfg_idx_i,
  input  wire logic [15:0]                          cfg_data_i,
  output logic                                      result_valid_o,
  output logic [ct_pkg::PT_W-1:0]                   point_x_o,
  output logic [ct_pkg::PT_W-1:0]                   point_y_o,
  output logic                                      first_of_path_o,
  output logic                                      backward_part_o,
  output logic                                      closed_path_o,
  output logic                                      last_of_path_o,
  output logic                                      scan_done_o
);
  import ct_pkg::*;

  localparam int SB = SAMPLE_BITS + 2;

  // Control and configuration state.
  state_e                 state_q, state_d;
  phase_e                 phase_q, phase_d;
  logic signed [SAMPLE_BITS-1:0] level_q, level_d;
  logic [GRID_W-1:0]      gcols_q, gcols_d, grows_q, grows_d;
  logic [COL_W-1:0]       scan_c_q, scan_c_d;
  logic [ROW_W-1:0]       scan_r_q, scan_r_d;
  logic [GRID_W-1:0]      tr_c_q, tr_c_d, tr_r_q, tr_r_d;
  dir_e                   dir_q, dir_d, sdir_q, sdir_d;
  logic [2:0]             cnt_q, cnt_d;

  // Per-word working registers.
  logic signed [SAMPLE_BITS-1:0] crn_q [4];
  logic signed [SAMPLE_BITS-1:0] crn_d [4];
  logic signed [SAMPLE_BITS-1:0] a_q, a_d;
  logic [ADDR_W-1:0]      pa_q, pa_d, pb_q, pb_d;
  logic [PT_W-1:0]        bx_q, bx_d, by_q, by_d;
  logic                   fx_q, fx_d;
  logic                   fl_first_q, fl_first_d, fl_back_q, fl_back_d;
  logic                   fl_closed_q, fl_closed_d, fl_last_q, fl_last_d;

  // Output registers.
  logic                   valid_d;
  logic [PT_W-1:0]        px_d, py_d;
  logic                   first_d, back_d, closed_d, last_d, done_d;

  // Memory ports.
  logic                   smp_we;
  logic [ADDR_W-1:0]      smp_addr;
  logic [SAMPLE_BITS-1:0] smp_wdata, smp_rdata;
  logic                   code_we;
  logic [ADDR_W-1:0]      code_addr;
  logic [CODE_W-1:0]      code_wdata, code_rdata;

  // Fraction unit.
  logic                   frac_go, frac_done;
  logic [FRAC_W-1:0]      frac_val;

  // Scratch values.
  logic [GRID_W-1:0]      lim_c, lim_r;
  logic [COL_W-1:0]       c6, c6p;
  logic [ROW_W-1:0]       r6, r6p;
  logic [CODE_W-1:0]      t, nt;
  dir_e                   nd;
  logic [GRID_W-1:0]      nc, nr, bc, br;
  dir_e                   bd;
  logic [SB-1:0]          csum, lev4;
  logic [CODE_W-1:0]      ccode;
  logic                   accept;

  function automatic logic [GRID_W-1:0] clamp_dim(input logic [GRID_W-1:0] v,
                                                  input int unsigned hi);
    logic [GRID_W-1:0] r;
    begin
      if (v < GRID_W'(2)) r = GRID_W'(2);
      else if (v > GRID_W'(hi)) r = GRID_W'(hi);
      else r = v;
      return r;
    end
  endfunction

  function automatic logic [PT_W-1:0] whole(input logic [COL_W-1:0] v);
    return PT_W'({v, {FRAC_BITS{1'b0}}});
  endfunction

  assign lim_c  = clamp_dim(gcols_q, MAX_COLS) - 1'b1;
  assign lim_r  = clamp_dim(grows_q, MAX_ROWS) - 1'b1;
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  ct_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NCELLS)) u_samples (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .addr_i  (smp_addr),
    .wdata_i (smp_wdata),
    .rdata_o (smp_rdata)
  );

  ct_ram #(.WIDTH(CODE_W), .DEPTH(NCELLS)) u_codes (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .addr_i  (code_addr),
    .wdata_i (code_wdata),
    .rdata_o (code_rdata)
  );

  ct_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (frac_go),
    .a_i     (a_q),
    .b_i     (smp_rdata),
    .level_i (level_q),
    .done_o  (frac_done),
    .frac_o  (frac_val)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    level_d     = level_q;
    gcols_d     = gcols_q;
    grows_d     = grows_q;
    scan_c_d    = scan_c_q;
    scan_r_d    = scan_r_q;
    tr_c_d      = tr_c_q;
    tr_r_d      = tr_r_q;
    dir_d       = dir_q;
    sdir_d      = sdir_q;
    cnt_d       = cnt_q;
    crn_d       = crn_q;
    a_d         = a_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    bx_d        = bx_q;
    by_d        = by_q;
    fx_d        = fx_q;
    fl_first_d  = fl_first_q;
    fl_back_d   = fl_back_q;
    fl_closed_d = fl_closed_q;
    fl_last_d   = fl_last_q;
    valid_d     = 1'b0;
    px_d        = point_x_o;
    py_d        = point_y_o;
    first_d     = first_of_path_o;
    back_d      = backward_part_o;
    closed_d    = closed_path_o;
    last_d      = last_of_path_o;
    done_d      = scan_done_o;
    smp_we      = 1'b0;
    smp_addr    = {row_i, col_i};
    smp_wdata   = sample_i;
    code_we     = 1'b0;
    code_addr   = {scan_r_q, scan_c_q};
    code_wdata  = '0;
    frac_go     = 1'b0;
    nt          = '0;
    nd          = dir_q;
    nc          = tr_c_q;
    nr          = tr_r_q;
    bc          = '0;
    br          = '0;
    bd          = D_LEFT;
    t           = code_rdata;

    // Cell coordinates of the scan position or the trace position.
    c6  = (state_q == ST_STEP_RD || state_q == ST_STEP_UPD) ? tr_c_q[COL_W-1:0] : scan_c_q;
    r6  = (state_q == ST_STEP_RD || state_q == ST_STEP_UPD) ? tr_r_q[ROW_W-1:0] : scan_r_q;
    c6p = c6 + 1'b1;
    r6p = r6 + 1'b1;

    // Corner classification with saddle resolution by the corner mean.
    csum  = SB'(crn_q[0]) + SB'(crn_q[1]) + SB'(crn_q[2]) + SB'(crn_q[3]);
    lev4  = SB'(level_q) <<< 2;
    ccode = {crn_q[3] >= level_q, crn_q[2] >= level_q,
             crn_q[1] >= level_q, crn_q[0] >= level_q};
    if (ccode == 4'd5) begin
      if ($signed(csum) < $signed(lev4)) ccode = 4'd8;
    end else if (ccode == 4'd10) begin
      ccode = ($signed(csum) > $signed(lev4)) ? 4'd5 : 4'd8;
    end else if (ccode >= 4'd8) begin
      ccode = 4'd15 - ccode;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEVEL: begin
          level_d = cfg_data_i;
          phase_d = PH_CLASSIFY;
        end
        REG_COLS: begin
          gcols_d = cfg_data_i[GRID_W-1:0];
          phase_d = PH_CLASSIFY;
        end
        REG_ROWS: begin
          grows_d = cfg_data_i[GRID_W-1:0];
          phase_d = PH_CLASSIFY;
        end
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_LOAD) begin
            smp_we  = 1'b1;
            phase_d = PH_CLASSIFY;
          end else begin
            case (phase_q)
              PH_CLASSIFY: begin
                scan_c_d = '0;
                scan_r_d = '0;
                cnt_d    = '0;
                state_d  = ST_CLS_RD;
              end
              PH_SCAN: state_d = ST_SCAN_RD;
              default: state_d = ST_STEP_RD;
            endcase
          end
        end
      end

      // Four corner reads, one per cycle, each captured in the cycle after its read.
      ST_CLS_RD: begin
        case (cnt_q)
          3'd0: smp_addr = {r6, c6};
          3'd1: smp_addr = {r6, c6p};
          3'd2: smp_addr = {r6p, c6p};
          default: smp_addr = {r6p, c6};
        endcase
        if (cnt_q != 3'd0) crn_d[cnt_q[1:0] - 2'd1] = smp_rdata;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd4) state_d = ST_CLS_WR;
      end

      ST_CLS_WR: begin
        code_we    = 1'b1;
        code_wdata = ccode;
        cnt_d      = '0;
        state_d    = ST_CLS_RD;
        if (GRID_W'(c6p) < lim_c) begin
          scan_c_d = c6p;
        end else if (GRID_W'(r6p) < lim_r) begin
          scan_c_d = '0;
          scan_r_d = r6p;
        end else begin
          scan_c_d = '0;
          scan_r_d = '0;
          phase_d  = PH_SCAN;
          state_d  = ST_SCAN_RD;
        end
      end

      ST_SCAN_RD: state_d = ST_SCAN_CHK;

      ST_SCAN_CHK: begin
        if (t != '0) begin
          // A new path starts at this cell.
          if (t == 4'd2 || t == 4'd6) begin
            pa_d = {r6, c6};  pb_d = {r6, c6p};
            bx_d = whole(c6); by_d = whole(r6); fx_d = 1'b1;
            sdir_d = D_UP;    dir_d = D_UP;
          end else if (t == 4'd4) begin
            pa_d = {r6p, c6}; pb_d = {r6p, c6p};
            bx_d = whole(c6); by_d = whole(r6p); fx_d = 1'b1;
            sdir_d = D_DOWN;  dir_d = D_DOWN;
          end else begin
            pa_d = {r6, c6};  pb_d = {r6p, c6};
            bx_d = whole(c6); by_d = whole(r6); fx_d = 1'b0;
            sdir_d = D_RIGHT; dir_d = D_RIGHT;
          end
          tr_c_d      = GRID_W'(c6);
          tr_r_d      = GRID_W'(r6);
          phase_d     = PH_FWD;
          fl_first_d  = 1'b1;
          fl_back_d   = 1'b0;
          fl_closed_d = 1'b0;
          fl_last_d   = 1'b0;
          cnt_d       = '0;
          state_d     = ST_PAIR;
        end else if (GRID_W'(c6p) < lim_c) begin
          scan_c_d = c6p;
          state_d  = ST_SCAN_RD;
        end else if (GRID_W'(r6p) < lim_r) begin
          scan_c_d = '0;
          scan_r_d = r6p;
          state_d  = ST_SCAN_RD;
        end else begin
          phase_d = PH_CLASSIFY;
          state_d = ST_EMIT;
        end
      end

      ST_STEP_RD: begin
        code_addr = {r6, c6};
        state_d   = ST_STEP_UPD;
      end

      ST_STEP_UPD: begin
        code_addr = {r6, c6};
        nt = t;
        nd = dir_q;
        case (t)
          4'd1: begin
            nt = '0;
            if (dir_q == D_RIGHT) nd = D_DOWN; else if (dir_q == D_UP) nd = D_LEFT;
          end
          4'd2: begin
            nt = '0;
            if (dir_q == D_UP) nd = D_RIGHT; else if (dir_q == D_LEFT) nd = D_DOWN;
          end
          4'd3, 4'd6: nt = '0;
          4'd4: begin
            nt = '0;
            if (dir_q == D_DOWN) nd = D_RIGHT; else if (dir_q == D_LEFT) nd = D_UP;
          end
          4'd7: begin
            nt = '0;
            if (dir_q == D_RIGHT) nd = D_UP; else if (dir_q == D_DOWN) nd = D_LEFT;
          end
          4'd5: begin
            case (dir_q)
              D_LEFT:  begin nd = D_UP;    nt = 4'd2; end
              D_DOWN:  begin nd = D_LEFT;  nt = 4'd2; end
              D_RIGHT: begin nd = D_DOWN;  nt = 4'd7; end
              default: begin nd = D_RIGHT; nt = 4'd7; end
            endcase
          end
          4'd8: begin
            case (dir_q)
              D_LEFT:  begin nd = D_UP;    nt = 4'd1; end
              D_DOWN:  begin nd = D_RIGHT; nt = 4'd1; end
              D_RIGHT: begin nd = D_DOWN;  nt = 4'd4; end
              default: begin nd = D_LEFT;  nt = 4'd4; end
            endcase
          end
          default: ;
        endcase
        code_we    = 1'b1;
        code_wdata = nt;
        dir_d      = nd;

        // Exit point on the edge that the path leaves through.
        case (nd)
          D_LEFT: begin
            pa_d = {r6, c6};  pb_d = {r6p, c6};
            bx_d = whole(c6); by_d = whole(r6); fx_d = 1'b0;
            nc = tr_c_q - 1'b1;
          end
          D_RIGHT: begin
            pa_d = {r6, c6p}; pb_d = {r6p, c6p};
            bx_d = whole(c6p); by_d = whole(r6); fx_d = 1'b0;
            nc = tr_c_q + 1'b1;
          end
          D_DOWN: begin
            pa_d = {r6, c6};  pb_d = {r6, c6p};
            bx_d = whole(c6); by_d = whole(r6); fx_d = 1'b1;
            nr = tr_r_q - 1'b1;
          end
          default: begin
            pa_d = {r6p, c6}; pb_d = {r6p, c6p};
            bx_d = whole(c6); by_d = whole(r6p); fx_d = 1'b1;
            nr = tr_r_q + 1'b1;
          end
        endcase
        tr_c_d = nc;
        tr_r_d = nr;

        // Cell behind the start, where a backward trace begins.
        bc = GRID_W'(scan_c_q);
        br = GRID_W'(scan_r_q);
        case (sdir_q)
          D_LEFT:  begin bd = D_RIGHT; bc = GRID_W'(scan_c_q) + 1'b1; end
          D_RIGHT: begin bd = D_LEFT;  bc = GRID_W'(scan_c_q) - 1'b1; end
          D_DOWN:  begin bd = D_UP;    br = GRID_W'(scan_r_q) + 1'b1; end
          default: begin bd = D_DOWN;  br = GRID_W'(scan_r_q) - 1'b1; end
        endcase

        fl_first_d  = 1'b0;
        fl_back_d   = (phase_q == PH_BWD);
        fl_closed_d = 1'b0;
        fl_last_d   = 1'b0;
        if (phase_q == PH_FWD) begin
          if (nc == GRID_W'(scan_c_q) && nr == GRID_W'(scan_r_q)) begin
            phase_d     = PH_SCAN;
            fl_closed_d = 1'b1;
            fl_last_d   = 1'b1;
          end else if (nc >= lim_c || nr >= lim_r) begin
            tr_c_d = bc;
            tr_r_d = br;
            dir_d  = bd;
            if (bc >= lim_c || br >= lim_r) begin
              phase_d   = PH_SCAN;
              fl_last_d = 1'b1;
            end else begin
              phase_d = PH_BWD;
            end
          end
        end else if (nc >= lim_c || nr >= lim_r) begin
          phase_d   = PH_SCAN;
          fl_last_d = 1'b1;
        end
        cnt_d   = '0;
        state_d = ST_PAIR;
      end

      // Read the edge samples at both ends, then hand them to the divider.
      ST_PAIR: begin
        smp_addr = (cnt_q == 3'd0) ? pa_q : pb_q;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 3'd1) a_d = smp_rdata;
        if (cnt_q == 3'd2) begin
          frac_go = 1'b1;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        if (frac_done) begin
          valid_d  = 1'b1;
          px_d     = bx_q + (fx_q ? PT_W'(frac_val) : '0);
          py_d     = by_q + (fx_q ? '0 : PT_W'(frac_val));
          first_d  = fl_first_q;
          back_d   = fl_back_q;
          closed_d = fl_closed_q;
          last_d   = fl_last_q;
          done_d   = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      ST_EMIT: begin
        valid_d  = 1'b1;
        px_d     = '0;
        py_d     = '0;
        first_d  = 1'b0;
        back_d   = 1'b0;
        closed_d = 1'b0;
        last_d   = 1'b0;
        done_d   = 1'b1;
        state_d  = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= PH_CLASSIFY;
      level_q        <= '0;
      gcols_q        <= GRID_W'(MAX_COLS);
      grows_q        <= GRID_W'(MAX_ROWS);
      scan_c_q       <= '0;
      scan_r_q       <= '0;
      tr_c_q         <= '0;
      tr_r_q         <= '0;
      dir_q          <= D_LEFT;
      sdir_q         <= D_LEFT;
      cnt_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      level_q        <= level_d;
      gcols_q        <= gcols_d;
      grows_q        <= grows_d;
      scan_c_q       <= scan_c_d;
      scan_r_q       <= scan_r_d;
      tr_c_q         <= tr_c_d;
      tr_r_q         <= tr_r_d;
      dir_q          <= dir_d;
      sdir_q         <= sdir_d;
      cnt_q          <= cnt_d;
      result_valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crn_q           <= crn_d;
    a_q             <= a_d;
    pa_q            <= pa_d;
    pb_q            <= pb_d;
    bx_q            <= bx_d;
    by_q            <= by_d;
    fx_q            <= fx_d;
    fl_first_q      <= fl_first_d;
    fl_back_q       <= fl_back_d;
    fl_closed_q     <= fl_closed_d;
    fl_last_q       <= fl_last_d;
    point_x_o       <= px_d;
    point_y_o       <= py_d;
    first_of_path_o <= first_d;
    backward_part_o <= back_d;
    closed_path_o   <= closed_d;
    last_of_path_o  <= last_d;
    scan_done_o     <= done_d;
  end

endmodule
`default_nettype wire

### bench/tb_contour_tracer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_contour_tracer: self-checking bench for the marching-squares tracer
// Loads sample grids of several sizes and levels, advances through the
// contours, and checks every point word against an in-bench tracer model.
// ----------------------------------------------------------------------------
module tb_contour_tracer;
  import ct_pkg::*;

  localparam int LIMIT = 4000000;

  typedef struct {
    logic                          op;
    logic [COL_W-1:0]              c;
    logic [ROW_W-1:0]              r;
    logic signed [SAMPLE_BITS-1:0] s;
  } word_t;

  typedef struct {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic            first;
    logic            back;
    logic            closed;
    logic            last;
    logic            done;
  } point_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          opcode_i = OP_LOAD;
  logic [COL_W-1:0]              col_i = '0;
  logic [ROW_W-1:0]              row_i = '0;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          cfg_we_i = 1'b0;
  logic [1:0]                    cfg_idx_i = REG_LEVEL;
  logic [15:0]                   cfg_data_i = '0;
  logic                          result_valid_o;
  logic [PT_W-1:0]               point_x_o, point_y_o;
  logic                          first_of_path_o, backward_part_o, closed_path_o;
  logic                          last_of_path_o, scan_done_o;

  contour_tracer uut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Words waiting to be driven and points waiting to come out.
  word_t  pending_words[$];
  point_t due_points[$];
  int     n_issued = 0;
  int     n_taken = 0;
  int     n_errors = 0;
  int     cycles = 0;

  // Tracer model state, held mostly in integers wider than the block's registers.
  int          grid_samples[NCELLS];
  logic [3:0]  cell_code[NCELLS];
  bit          loaded[NCELLS];
  longint      lvl = 0;
  int          cols_reg = 64, rows_reg = 64;
  int          scan_c = 0, scan_r = 0, walk_c = 0, walk_r = 0;
  dir_e        walk_dir = D_LEFT, entry_dir = D_LEFT;
  phase_e      stage = PH_CLASSIFY;

  function automatic int cell_ix(int c, int r);
    return (c + r * MAX_COLS) & (NCELLS - 1);
  endfunction

  function automatic int cols_used();
    return cols_reg < 2 ? 2 : (cols_reg > MAX_COLS ? MAX_COLS : cols_reg);
  endfunction

  function automatic int rows_used();
    return rows_reg < 2 ? 2 : (rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg);
  endfunction

  function automatic longint smp(int c, int r);
    return grid_samples[cell_ix(c, r)];
  endfunction

  function automatic bit off_grid(int c, int r);
    return c < 0 || c >= cols_used() - 1 || r < 0 || r >= rows_used() - 1;
  endfunction

  // Crossing position along an edge from a to b, 8 fraction bits, held to 0..1.
  function automatic longint edge_frac(longint a, longint b);
    longint num, den, q;
    num = lvl - a;
    den = b - a;
    if (den == 0) return 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 0;
    q = (num << FRAC_BITS) / den;
    return q > (1 << FRAC_BITS) ? (1 << FRAC_BITS) : q;
  endfunction

  // Folds corner bits to codes 0..8 and resolves the two saddles by the sum.
  function automatic void classify_grid();
    longint s0, s1, s2, s3, sum;
    int t;
    for (int r = 0; r < rows_used() - 1; r++) begin
      for (int c = 0; c < cols_used() - 1; c++) begin
        s0 = smp(c, r);
        s1 = smp(c + 1, r);
        s2 = smp(c + 1, r + 1);
        s3 = smp(c, r + 1);
        sum = s0 + s1 + s2 + s3;
        t = int'(s0 >= lvl) | (int'(s1 >= lvl) << 1) | (int'(s2 >= lvl) << 2)
            | (int'(s3 >= lvl) << 3);
        if (t == 5) begin
          if (sum < 4 * lvl) t = 8;
        end else if (t == 10) begin
          t = (sum > 4 * lvl) ? 5 : 8;
        end else if (t >= 8) begin
          t = 15 - t;
        end
        cell_code[cell_ix(c, r)] = t[3:0];
      end
    end
  endfunction

  // One move of the walker: clears or splits the cell code, turns, gives the
  // exit point and moves into the neighbor cell.
  function automatic void walk_step(output longint px, output longint py);
    int   c, r, k, t;
    dir_e d;
    c = walk_c;
    r = walk_r;
    k = cell_ix(c, r);
    t = cell_code[k];
    d = walk_dir;
    case (t)
      1: begin
        t = 0;
        if (d == D_RIGHT) d = D_DOWN; else if (d == D_UP) d = D_LEFT;
      end
      2: begin
        t = 0;
        if (d == D_UP) d = D_RIGHT; else if (d == D_LEFT) d = D_DOWN;
      end
      3, 6: t = 0;
      4: begin
        t = 0;
        if (d == D_DOWN) d = D_RIGHT; else if (d == D_LEFT) d = D_UP;
      end
      7: begin
        t = 0;
        if (d == D_RIGHT) d = D_UP; else if (d == D_DOWN) d = D_LEFT;
      end
      5: begin
        if (d == D_LEFT) begin d = D_UP; t = 2; end
        else if (d == D_DOWN) begin d = D_LEFT; t = 2; end
        else if (d == D_RIGHT) begin d = D_DOWN; t = 7; end
        else begin d = D_RIGHT; t = 7; end
      end
      8: begin
        if (d == D_LEFT) begin d = D_UP; t = 1; end
        else if (d == D_DOWN) begin d = D_RIGHT; t = 1; end
        else if (d == D_RIGHT) begin d = D_DOWN; t = 4; end
        else begin d = D_LEFT; t = 4; end
      end
      default: ;
    endcase
    cell_code[k] = t[3:0];
    walk_dir = d;
    case (d)
      D_LEFT: begin
        px = longint'(c) << FRAC_BITS;
        py = (longint'(r) << FRAC_BITS) + edge_frac(smp(c, r), smp(c, r + 1));
        walk_c = c - 1;
      end
      D_RIGHT: begin
        px = longint'(c + 1) << FRAC_BITS;
        py = (longint'(r) << FRAC_BITS) + edge_frac(smp(c + 1, r), smp(c + 1, r + 1));
        walk_c = c + 1;
      end
      D_DOWN: begin
        px = (longint'(c) << FRAC_BITS) + edge_frac(smp(c, r), smp(c + 1, r));
        py = longint'(r) << FRAC_BITS;
        walk_r = r - 1;
      end
      default: begin
        px = (longint'(c) << FRAC_BITS) + edge_frac(smp(c, r + 1), smp(c + 1, r + 1));
        py = longint'(r + 1) << FRAC_BITS;
        walk_r = r + 1;
      end
    endcase
  endfunction

  function automatic void push_point(longint x, longint y, bit first, bit back,
                                     bit closed, bit last, bit done);
    point_t p;
    p.x = x[PT_W-1:0];
    p.y = y[PT_W-1:0];
    p.first = first;
    p.back = back;
    p.closed = closed;
    p.last = last;
    p.done = done;
    due_points.push_back(p);
  endfunction

  // Works out the point word, if any, that one accepted word causes.
  function automatic void predict_word(word_t w);
    longint x, y;
    int     c, r, t;
    bit     found;
    if (w.op == OP_LOAD) begin
      grid_samples[cell_ix(w.c, w.r)] = w.s;
      stage = PH_CLASSIFY;
      return;
    end
    if (stage == PH_CLASSIFY) begin
      classify_grid();
      scan_c = 0;
      scan_r = 0;
      stage = PH_SCAN;
    end
    if (stage == PH_SCAN) begin
      found = 0;
      t = 0;
      for (r = scan_r; r < rows_used() - 1 && !found; r++) begin
        for (c = (r == scan_r) ? scan_c : 0; c < cols_used() - 1; c++) begin
          t = cell_code[cell_ix(c, r)];
          if (t != 0) begin
            scan_c = c;
            scan_r = r;
            found = 1;
            break;
          end
        end
      end
      if (!found) begin
        stage = PH_CLASSIFY;
        push_point(0, 0, 0, 0, 0, 0, 1);
        return;
      end
      c = scan_c;
      r = scan_r;
      if (t == 2 || t == 6) begin
        x = (longint'(c) << FRAC_BITS) + edge_frac(smp(c, r), smp(c + 1, r));
        y = longint'(r) << FRAC_BITS;
        entry_dir = D_UP;
      end else if (t == 4) begin
        x = (longint'(c) << FRAC_BITS) + edge_frac(smp(c, r + 1), smp(c + 1, r + 1));
        y = longint'(r + 1) << FRAC_BITS;
        entry_dir = D_DOWN;
      end else begin
        x = longint'(c) << FRAC_BITS;
        y = (longint'(r) << FRAC_BITS) + edge_frac(smp(c, r), smp(c, r + 1));
        entry_dir = D_RIGHT;
      end
      walk_c = c;
      walk_r = r;
      walk_dir = entry_dir;
      stage = PH_FWD;
      push_point(x, y, 1, 0, 0, 0, 0);
      return;
    end
    walk_step(x, y);
    if (stage == PH_FWD) begin
      if (walk_c == scan_c && walk_r == scan_r) begin
        stage = PH_SCAN;
        push_point(x, y, 0, 0, 1, 1, 0);
      end else if (off_grid(walk_c, walk_r)) begin
        // The forward trace left the grid: turn around behind the start cell.
        walk_c = scan_c;
        walk_r = scan_r;
        case (entry_dir)
          D_LEFT:  begin walk_dir = D_RIGHT; walk_c = scan_c + 1; end
          D_RIGHT: begin walk_dir = D_LEFT;  walk_c = scan_c - 1; end
          D_DOWN:  begin walk_dir = D_UP;    walk_r = scan_r + 1; end
          default: begin walk_dir = D_DOWN;  walk_r = scan_r - 1; end
        endcase
        if (off_grid(walk_c, walk_r)) begin
          stage = PH_SCAN;
          push_point(x, y, 0, 0, 0, 1, 0);
        end else begin
          stage = PH_BWD;
          push_point(x, y, 0, 0, 0, 0, 0);
        end
      end else begin
        push_point(x, y, 0, 0, 0, 0, 0);
      end
    end else begin
      if (off_grid(walk_c, walk_r)) begin
        stage = PH_SCAN;
        push_point(x, y, 0, 1, 0, 1, 0);
      end else begin
        push_point(x, y, 0, 1, 0, 0, 0);
      end
    end
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, field, got, want);
    n_errors++;
  endtask

  // Monitor: checks a shown point word first, then takes in an accepted word,
  // so a point and a new word on the same edge keep their order.
  always @(posedge clk_i) begin
    point_t p;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (due_points.size() == 0) begin
          report("unexpected point words", 1, 0);
        end else begin
          p = due_points.pop_front();
          if (point_x_o !== p.x) report("point_x", point_x_o, p.x);
          if (point_y_o !== p.y) report("point_y", point_y_o, p.y);
          if (first_of_path_o !== p.first) report("first_of_path", first_of_path_o, p.first);
          if (backward_part_o !== p.back) report("backward_part", backward_part_o, p.back);
          if (closed_path_o !== p.closed) report("closed_path", closed_path_o, p.closed);
          if (last_of_path_o !== p.last) report("last_of_path", last_of_path_o, p.last);
          if (scan_done_o !== p.done) report("scan_done", scan_done_o, p.done);
        end
      end
      if (start && !busy) begin
        predict_word('{opcode_i, col_i, row_i, sample_i});
        n_taken++;
      end
    end
    if (cycles == LIMIT) begin
      $display("timeout");
      $display("tb_contour_tracer: errors");
      $finish;
    end
  end

  // Driver: puts the next word up at the falling edge once the last one went
  // through, with a random gap after each word. In calm stretches the gap is
  // zero so start stays high across back-to-back words.
  int gap = 0;
  int calm_left = 0;
  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (start && n_taken != n_issued) begin
        // Still waiting for the word on the ports to be taken.
      end else if (gap > 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        opcode_i <= w.op;
        col_i <= w.c;
        row_i <= w.r;
        sample_i <= w.s;
        start <= 1'b1;
        n_issued++;
        if (calm_left > 0) begin
          calm_left <= calm_left - 1;
          gap <= 0;
        end else begin
          if ($urandom_range(0, 30) == 0) calm_left <= $urandom_range(10, 60);
          gap <= $urandom_range(0, 10);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Samples cluster around the level so contours are dense; a narrow spread
  // gives flat edges and saddles, and some draws hit the extremes.
  function automatic logic signed [15:0] draw_sample(int spread);
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sd32767 : 16'sh8000;
      default: return clip16(lvl + $signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  function automatic void queue_load(int c, int r, logic signed [15:0] s);
    pending_words.push_back('{OP_LOAD, c[COL_W-1:0], r[ROW_W-1:0], s});
    loaded[cell_ix(c, r)] = 1;
  endfunction

  function automatic void queue_advance();
    pending_words.push_back('{1'b1, 6'($urandom), 6'($urandom), 16'($urandom)});
  endfunction

  // Waits until every word went through and every point came out, then lets
  // the block settle before touching its registers.
  task automatic wait_quiet();
    while (pending_words.size() != 0 || n_taken != n_issued || start
           || due_points.size() != 0 || busy)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LEVEL: lvl = longint'($signed(data));
      REG_COLS:  cols_reg = data[6:0];
      REG_ROWS:  rows_reg = data[6:0];
      default:   return;
    endcase
    stage = PH_CLASSIFY;
  endtask

  // One run of the stimulus at one setting: the grid in use is loaded first,
  // since a sample read before it was written is not allowed.
  task automatic run_setting(logic [15:0] level_v, logic [15:0] cols_v,
                             logic [15:0] rows_v, int n_words, int spread);
    int loads_pct;
    write_reg(REG_LEVEL, level_v);
    write_reg(REG_COLS, cols_v);
    write_reg(REG_ROWS, rows_v);
    for (int r = 0; r < rows_used(); r++)
      for (int c = 0; c < cols_used(); c++)
        if (!loaded[cell_ix(c, r)] || $urandom_range(0, 3) == 0)
          queue_load(c, r, draw_sample(spread));
    // Large grids reclassify slowly, so they see few loads between advances.
    loads_pct = (cols_used() * rows_used() > 64) ? 3 : 15;
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 99) < loads_pct)
        queue_load($urandom_range(0, 63), $urandom_range(0, 63), draw_sample(spread));
      else
        queue_advance();
    end
    wait_quiet();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a 3 x 3 grid holding a saddle in the corner cell, a flat
    // edge, and both sample extremes, traced to the end of the scan.
    write_reg(REG_COLS, 16'd3);
    write_reg(REG_ROWS, 16'd3);
    queue_load(0, 0, 16'sd100);
    queue_load(1, 0, -16'sd100);
    queue_load(1, 1, 16'sd100);
    queue_load(0, 1, -16'sd100);
    queue_load(2, 0, -16'sd100);
    queue_load(2, 1, 16'sd32767);
    queue_load(0, 2, 16'sh8000);
    queue_load(1, 2, 16'sh8000);
    queue_load(2, 2, 16'sd0);
    repeat (14) queue_advance();
    wait_quiet();
    // The unused index does nothing; the scan carries on where it stood.
    write_reg(reg_e'(2'd3), 16'hFFFF);
    repeat (4) queue_advance();
    wait_quiet();

    // Register extremes, clamped sizes and long thin grids.
    run_setting(16'h8000, 16'd0, 16'd1, 20, 40);
    run_setting(16'h7FFF, 16'd127, 16'd2, 120, 40);
    run_setting(16'h0000, 16'hFF82, 16'd64, 150, 40);
    run_setting(16'hFFF0, 16'd64, 16'd3, 150, 2);
    run_setting(16'd50, 16'd2, 16'd2, 60, 1);
    for (int i = 0; i < 9; i++)
      run_setting(16'($urandom_range(0, 400)) - 16'd200,
                  {9'($urandom_range(0, 511)), 7'($urandom_range(2, 12))},
                  {9'($urandom_range(0, 511)), 7'($urandom_range(2, 12))},
                  80, (i % 3 == 0) ? 1 : 60);

    repeat (50) @(negedge clk_i);
    if (n_errors == 0 && due_points.size() == 0) begin
      $display("tb_contour_tracer: clean");
    end else begin
      $display("tb_contour_tracer: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

### contour_tracer.f
hw/rtl/ct_pkg.sv
hw/rtl/ct_ram.sv
hw/rtl/ct_frac.sv
hw/rtl/contour_tracer.sv
bench/tb_contour_tracer.sv
